FILE: hdl/tilt_compensated_heading_defines.svh
// ---------------------------------------------------------------------------
// Tilt-compensated heading: assertion macros
// Shared property wrappers for the checker, clocked on clk, quiet in reset.
// ---------------------------------------------------------------------------
`ifndef TILT_COMPENSATED_HEADING_DEFINES_SVH
`define TILT_COMPENSATED_HEADING_DEFINES_SVH

// cond must hold at every edge outside reset
`define THC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define THC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define THC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/thc_pkg.sv
// ---------------------------------------------------------------------------
// thc_pkg
// Types, constants and helper functions of the tilt-compensated heading pipe.
// ---------------------------------------------------------------------------
package thc_pkg;

  localparam int CORDIC_STAGES   = 16;   // 8..24
  localparam int ANGLE_TABLE_LEN = 24;
  localparam int X_W             = 34;   // vector datapath, inputs scaled by 2^12
  localparam int Z_W             = 26;   // angle datapath, 2^-16 degree
  localparam int CORDIC_LAT      = CORDIC_STAGES + 2;
  localparam int PIPE_LAT        = 5 * CORDIC_LAT + 1;

  typedef logic signed [X_W-1:0] xval_t;
  typedef logic signed [Z_W-1:0] zval_t;
  typedef logic signed [15:0]    samp_t;
  typedef logic signed [15:0]    qang_t;

  localparam zval_t DEG90  = zval_t'(5898240);
  localparam zval_t DEG180 = zval_t'(11796480);

  // atan(2^-i) in 2^-16 degree
  localparam zval_t STAGE_ANGLE [ANGLE_TABLE_LEN] = '{
    zval_t'(2949120), zval_t'(1740967), zval_t'(919879), zval_t'(466945),
    zval_t'(234379),  zval_t'(117304),  zval_t'(58666),  zval_t'(29335),
    zval_t'(14668),   zval_t'(7334),    zval_t'(3667),   zval_t'(1833),
    zval_t'(917),     zval_t'(458),     zval_t'(229),    zval_t'(115),
    zval_t'(57),      zval_t'(29),      zval_t'(14),     zval_t'(7),
    zval_t'(4),       zval_t'(2),       zval_t'(1),      zval_t'(0)
  };

  localparam logic signed [30:0] INV_GAIN_Q30 = 31'sd652032874;

  localparam int FULL_TURN   = 23040;
  localparam int ROLL_LIMIT  = 11520;
  localparam int PITCH_LIMIT = 5760;
  localparam int FIELD_MAX   = 65535;

  function automatic xval_t scale_in(samp_t s);
    return {{(X_W-28){s[15]}}, s, 12'b0};
  endfunction

  // multiply by 1/K in Q30, round, floor shift
  function automatic xval_t remove_gain(xval_t v);
    logic signed [X_W+30:0] p;
    p = v * INV_GAIN_Q30;
    p = p + (X_W+31)'(64'sd536870912);
    return p[X_W+29:30];
  endfunction

  // 2^-16 degree to 1/64 degree, round half up
  function automatic qang_t round_angle(zval_t a);
    zval_t t;
    t = a + zval_t'(512);
    return t[Z_W-1:10];
  endfunction

endpackage

FILE: hdl/thc_vec.sv
// ---------------------------------------------------------------------------
// thc_vec
// Pipelined vectoring CORDIC: angle and gain-corrected magnitude of (x, y).
// ---------------------------------------------------------------------------
module thc_vec (
  input  logic            clk,
  input  logic            en,
  input  thc_pkg::xval_t  x_in,
  input  thc_pkg::xval_t  y_in,
  output thc_pkg::zval_t  ang,
  output thc_pkg::xval_t  mag
);

  localparam int N = thc_pkg::CORDIC_STAGES;

  thc_pkg::xval_t xs [N+1];
  thc_pkg::xval_t ys [N+1];
  thc_pkg::zval_t zs [N+1];
  logic           zf [N+1];

  // left half plane turned by 90 degrees first
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          xs[0] <= y_in;
          ys[0] <= -x_in;
          zs[0] <= thc_pkg::DEG90;
        end else begin
          xs[0] <= -y_in;
          ys[0] <= x_in;
          zs[0] <= -thc_pkg::DEG90;
        end
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + thc_pkg::STAGE_ANGLE[i];
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - thc_pkg::STAGE_ANGLE[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= thc_pkg::remove_gain(xs[N]);
      ang <= zf[N] ? '0 : zs[N];
    end
  end

endmodule

FILE: hdl/thc_rot.sv
// ---------------------------------------------------------------------------
// thc_rot
// Pipelined rotation CORDIC: turns (x, y) by angle z, gain corrected.
// ---------------------------------------------------------------------------
module thc_rot (
  input  logic            clk,
  input  logic            en,
  input  thc_pkg::xval_t  x_in,
  input  thc_pkg::xval_t  y_in,
  input  thc_pkg::zval_t  z_in,
  output thc_pkg::xval_t  x_out,
  output thc_pkg::xval_t  y_out
);

  localparam int N = thc_pkg::CORDIC_STAGES;

  thc_pkg::xval_t xs [N+1];
  thc_pkg::xval_t ys [N+1];
  thc_pkg::zval_t zs [N+1];

  // fold angles beyond +-90 degrees by 180 and negate the vector
  always_ff @(posedge clk) begin
    if (en) begin
      if (z_in > thc_pkg::DEG90) begin
        xs[0] <= -x_in;
        ys[0] <= -y_in;
        zs[0] <= z_in - thc_pkg::DEG180;
      end else if (z_in < -thc_pkg::DEG90) begin
        xs[0] <= -x_in;
        ys[0] <= -y_in;
        zs[0] <= z_in + thc_pkg::DEG180;
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= z_in;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - thc_pkg::STAGE_ANGLE[i];
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + thc_pkg::STAGE_ANGLE[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= thc_pkg::remove_gain(xs[N]);
      y_out <= thc_pkg::remove_gain(ys[N]);
    end
  end

endmodule

FILE: hdl/tilt_compensated_heading.sv
// ---------------------------------------------------------------------------
// tilt_compensated_heading
// Roll, pitch, tilt-compensated heading and field magnitude from one
// accelerometer and magnetometer sample.
// ---------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one sample (accel_x/y/z, mag_x/y/z)
// per beat; output channel out_valid/out_ready carries field_total,
// roll_angle, pitch_angle and heading_angle per beat, one result per sample,
// in order.
// The chain is five CORDIC units (roll, pitch, two rotations, heading),
// each a pre-turn register, one register per micro-rotation and a
// gain-multiply register, then one register for rounding, clamping and
// heading wrap. The field magnitude runs in two CORDICs alongside the chain.
// Throughput is one sample per cycle while no valid result is stalled.
// Reset clears all valid bits; the pipe comes up empty with in_ready high.
// When the receiver stalls a valid result, the whole pipe holds and in_ready
// drops in the same cycle; it restarts with nothing lost or repeated.
// ---------------------------------------------------------------------------
module tilt_compensated_heading (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] accel_x,
  input  logic [15:0] accel_y,
  input  logic [15:0] accel_z,
  input  logic [15:0] mag_x,
  input  logic [15:0] mag_y,
  input  logic [15:0] mag_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] field_total,
  output logic [14:0] roll_angle,
  output logic [13:0] pitch_angle,
  output logic [14:0] heading_angle
);

  localparam int L = thc_pkg::CORDIC_LAT;
  localparam int P = thc_pkg::PIPE_LAT;
  localparam int X_Q = thc_pkg::X_W - 12;

  logic en;
  logic vld [P];

  thc_pkg::samp_t ax_d [L];
  thc_pkg::samp_t mz_d [2*L];
  thc_pkg::samp_t mx_d [2*L];
  thc_pkg::samp_t my_d [3*L];
  thc_pkg::zval_t roll_d [4*L];
  thc_pkg::zval_t pitch_d [3*L];
  thc_pkg::xval_t tot_d [3*L];
  thc_pkg::xval_t bx_d [L];

  thc_pkg::zval_t roll, pitch, head;
  thc_pkg::xval_t rho, bx, t, by, r1, tot;

  thc_pkg::qang_t qr, qp, qh;
  logic signed [16:0] qh_w;
  logic signed [X_Q-1:0] qt;
  thc_pkg::xval_t tot_r;

  logic [15:0] field_next;
  logic [14:0] roll_next, heading_next;
  logic [13:0] pitch_next;

  assign en        = !vld[P-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[P-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < P; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < P; k++) vld[k] <= vld[k-1];
    end
  end

  // side data delay lines, aligned to each unit's input and to the output stage
  always_ff @(posedge clk) begin
    if (en) begin
      ax_d[0]    <= accel_x;
      mz_d[0]    <= mag_z;
      mx_d[0]    <= mag_x;
      my_d[0]    <= mag_y;
      roll_d[0]  <= roll;
      pitch_d[0] <= pitch;
      tot_d[0]   <= tot;
      bx_d[0]    <= bx;
      for (int k = 1; k < L; k++) begin
        ax_d[k] <= ax_d[k-1];
        bx_d[k] <= bx_d[k-1];
      end
      for (int k = 1; k < 2*L; k++) begin
        mz_d[k] <= mz_d[k-1];
        mx_d[k] <= mx_d[k-1];
      end
      for (int k = 1; k < 3*L; k++) begin
        my_d[k]    <= my_d[k-1];
        pitch_d[k] <= pitch_d[k-1];
        tot_d[k]   <= tot_d[k-1];
      end
      for (int k = 1; k < 4*L; k++) roll_d[k] <= roll_d[k-1];
    end
  end

  thc_vec u_roll (
    .clk (clk), .en (en),
    .x_in (thc_pkg::scale_in(accel_z)), .y_in (thc_pkg::scale_in(accel_y)),
    .ang (roll), .mag (rho)
  );

  thc_vec u_pitch (
    .clk (clk), .en (en),
    .x_in (rho), .y_in (-thc_pkg::scale_in(ax_d[L-1])),
    .ang (pitch), .mag ()
  );

  thc_rot u_rot_p (
    .clk (clk), .en (en),
    .x_in (thc_pkg::scale_in(mx_d[2*L-1])), .y_in (-thc_pkg::scale_in(mz_d[2*L-1])),
    .z_in (pitch),
    .x_out (bx), .y_out (t)
  );

  thc_rot u_rot_r (
    .clk (clk), .en (en),
    .x_in (thc_pkg::scale_in(my_d[3*L-1])), .y_in (-t),
    .z_in (roll_d[2*L-1]),
    .x_out (by), .y_out ()
  );

  thc_vec u_head (
    .clk (clk), .en (en),
    .x_in (bx_d[L-1]), .y_in (-by),
    .ang (head), .mag ()
  );

  thc_vec u_mag_xy (
    .clk (clk), .en (en),
    .x_in (thc_pkg::scale_in(mag_x)), .y_in (thc_pkg::scale_in(mag_y)),
    .ang (), .mag (r1)
  );

  thc_vec u_mag_xyz (
    .clk (clk), .en (en),
    .x_in (r1), .y_in (thc_pkg::scale_in(mz_d[L-1])),
    .ang (), .mag (tot)
  );

  // output rounding, clamps and heading wrap
  always_comb begin
    qr = thc_pkg::round_angle(roll_d[4*L-1]);
    if (qr > thc_pkg::ROLL_LIMIT)       roll_next = 15'(thc_pkg::ROLL_LIMIT);
    else if (qr < -thc_pkg::ROLL_LIMIT) roll_next = 15'(-thc_pkg::ROLL_LIMIT);
    else                                roll_next = qr[14:0];

    qp = thc_pkg::round_angle(pitch_d[3*L-1]);
    if (qp > thc_pkg::PITCH_LIMIT)       pitch_next = 14'(thc_pkg::PITCH_LIMIT);
    else if (qp < -thc_pkg::PITCH_LIMIT) pitch_next = 14'(-thc_pkg::PITCH_LIMIT);
    else                                 pitch_next = qp[13:0];

    qh   = thc_pkg::round_angle(head);
    qh_w = 17'(qh);
    if (qh_w < 0) qh_w = qh_w + 17'(thc_pkg::FULL_TURN);
    if (qh_w >= thc_pkg::FULL_TURN) qh_w = qh_w - 17'(thc_pkg::FULL_TURN);
    if (qh_w < 0)                            heading_next = '0;
    else if (qh_w > thc_pkg::FULL_TURN - 1) heading_next = 15'(thc_pkg::FULL_TURN - 1);
    else                                     heading_next = qh_w[14:0];

    tot_r = tot_d[3*L-1] + thc_pkg::xval_t'(2048);
    qt    = tot_r[thc_pkg::X_W-1:12];
    if (qt < 0)                        field_next = '0;
    else if (qt > thc_pkg::FIELD_MAX)  field_next = 16'(thc_pkg::FIELD_MAX);
    else                               field_next = qt[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      field_total   <= field_next;
      roll_angle    <= roll_next;
      pitch_angle   <= pitch_next;
      heading_angle <= heading_next;
    end
  end

endmodule

FILE: hdl/thc_checker.sv
// ---------------------------------------------------------------------------
// thc_checker
// Port-level checks on the heading pipe, bound to the top level.
// ---------------------------------------------------------------------------
`include "tilt_compensated_heading_defines.svh"

module thc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] field_total,
  input logic [14:0] roll_angle,
  input logic [13:0] pitch_angle,
  input logic [14:0] heading_angle
);

  // a stalled result beat holds
  `THC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(field_total) && $stable(roll_angle) &&
    $stable(pitch_angle) && $stable(heading_angle), "stalled result changed")

  // pipe only stops for a stalled result
  `THC_ASSERT_IMPL(a_ready, !out_valid || out_ready, in_ready, "input blocked without stall")

  `THC_ASSERT_IMPL(a_head_range, out_valid, heading_angle < 15'd23040, "heading not wrapped")

  `THC_ASSERT_IMPL(a_tilt_range, out_valid,
    ($signed(roll_angle) <= 15'sd11520) && ($signed(roll_angle) >= -15'sd11520) &&
    ($signed(pitch_angle) <= 14'sd5760) && ($signed(pitch_angle) >= -14'sd5760),
    "tilt out of range")

endmodule

bind tilt_compensated_heading thc_checker u_thc_checker (.*);
